// ----- src/ism_pkg.sv -----
// Shared types and constants for the image stack median core.
// No dependencies; imported by every module of the block.
package ism_pkg;

  // Number of image slots carried by one request (one pixel port per slot).
  localparam int MaxImages = 9;

  // Width of the images-in-use register and of a sorted position.
  localparam int CntW = 4;

  // Reset value of the images-in-use register.
  localparam logic [CntW-1:0] CountReset = CntW'(MaxImages);

  typedef logic [CntW-1:0] cnt_t;

  // Control state of the input stage.
  typedef struct packed {
    logic valid;
    cnt_t count;
  } stage_ctrl_t;

endpackage

// ----- src/ism_rank.sv -----
// Descending-order position of every used pixel of the stack.
// Depends on ism_pkg.
module ism_rank
  import ism_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic [PIXEL_BITS-1:0] pix_i  [MaxImages],
  input  cnt_t                  count_i,
  output cnt_t                  rank_o [MaxImages],
  output logic [MaxImages-1:0]  used_o
);

  logic [MaxImages-1:0] ahead [MaxImages];

  always_comb begin
    for (int i = 0; i < MaxImages; i++) begin
      used_o[i] = (CntW'(i) < count_i);
    end
    // Element j sits ahead of element i if larger, or equal and from a lower slot.
    for (int i = 0; i < MaxImages; i++) begin
      for (int j = 0; j < MaxImages; j++) begin
        ahead[i][j] = used_o[j] && (j != i) &&
                      ((pix_i[j] > pix_i[i]) || ((pix_i[j] == pix_i[i]) && (j < i)));
      end
    end
    for (int i = 0; i < MaxImages; i++) begin
      rank_o[i] = '0;
      for (int j = 0; j < MaxImages; j++) begin
        rank_o[i] = rank_o[i] + CntW'(ahead[i][j]);
      end
    end
  end

endmodule

// ----- src/ism_select.sv -----
// Pick the pixel whose sorted position is count/2.
// Depends on ism_pkg.
module ism_select
  import ism_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic [PIXEL_BITS-1:0] pix_i  [MaxImages],
  input  cnt_t                  rank_i [MaxImages],
  input  logic [MaxImages-1:0]  used_i,
  input  cnt_t                  count_i,
  output logic [MaxImages-1:0]  hit_o,
  output logic [PIXEL_BITS-1:0] median_o
);

  cnt_t target;

  always_comb begin
    target   = count_i >> 1;
    median_o = '0;
    for (int i = 0; i < MaxImages; i++) begin
      hit_o[i] = used_i[i] && (rank_i[i] == target);
      median_o = median_o | (pix_i[i] & {PIXEL_BITS{hit_o[i]}});
    end
  end

endmodule

// ----- src/image_stack_median_core.sv -----
// Image stack median core: an accepted request passes the input registers, then the result registers, to the strobe.
// Throughput one request per cycle; busy_o stays low, start_i may be held high every cycle.
// Rate is set by one rank/select pass between the input and result registers.
// The receiver cannot stall: each result shows for exactly one cycle on result_valid_o.
// rst_ni (async, active low) drops all requests in flight and sets images-in-use to 9.
// Depends on ism_pkg, ism_rank and ism_select.
module image_stack_median_core
  import ism_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CntW-1:0]       cfg_images_in_use_i,
  // request side
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [PIXEL_BITS-1:0] pixel_0_i,
  input  logic [PIXEL_BITS-1:0] pixel_1_i,
  input  logic [PIXEL_BITS-1:0] pixel_2_i,
  input  logic [PIXEL_BITS-1:0] pixel_3_i,
  input  logic [PIXEL_BITS-1:0] pixel_4_i,
  input  logic [PIXEL_BITS-1:0] pixel_5_i,
  input  logic [PIXEL_BITS-1:0] pixel_6_i,
  input  logic [PIXEL_BITS-1:0] pixel_7_i,
  input  logic [PIXEL_BITS-1:0] pixel_8_i,
  // result side
  output logic                  result_valid_o,
  output logic [PIXEL_BITS-1:0] median_pixel_o
);

  // Images-in-use register, raw as written.
  cnt_t cfg_q;

  // Input stage: pixels plus control.
  stage_ctrl_t                 in_ctrl_q, in_ctrl_d;
  logic [PIXEL_BITS-1:0]       pix_q [MaxImages];
  logic [PIXEL_BITS-1:0]       pix_d [MaxImages];

  // Result stage.
  logic                        res_vld_q;
  logic [PIXEL_BITS-1:0]       res_pix_q, res_pix_d;

  cnt_t                        count_eff;
  cnt_t                        rank   [MaxImages];
  logic [MaxImages-1:0]        used;
  logic [MaxImages-1:0]        hit;

  // Always able to take a request and a config write.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Saturate the count to the number of slots.
  assign count_eff = (cfg_q > CntW'(MaxImages)) ? CntW'(MaxImages) : cfg_q;

  always_comb begin
    pix_d[0] = pixel_0_i;
    pix_d[1] = pixel_1_i;
    pix_d[2] = pixel_2_i;
    pix_d[3] = pixel_3_i;
    pix_d[4] = pixel_4_i;
    pix_d[5] = pixel_5_i;
    pix_d[6] = pixel_6_i;
    pix_d[7] = pixel_7_i;
    pix_d[8] = pixel_8_i;
    in_ctrl_d.valid = start_i && !busy_o;
    in_ctrl_d.count = count_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_images_in_use_i;
    end
  end

  // Control registers: reset drops anything in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctrl_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      in_ctrl_q <= in_ctrl_d;
      res_vld_q <= in_ctrl_q.valid;
    end
  end

  // Payload registers: capture on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_ctrl_d.valid) begin
      pix_q <= pix_d;
    end
    if (in_ctrl_q.valid) begin
      res_pix_q <= res_pix_d;
    end
  end

  // Rank every used pixel, then pick the one at position count/2.
  ism_rank #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_rank (
    .pix_i  (pix_q),
    .count_i(in_ctrl_q.count),
    .rank_o (rank),
    .used_o (used)
  );

  ism_select #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_select (
    .pix_i   (pix_q),
    .rank_i  (rank),
    .used_i  (used),
    .count_i (in_ctrl_q.count),
    .hit_o   (hit),
    .median_o(res_pix_d)
  );

  assign result_valid_o = res_vld_q;
  assign median_pixel_o = res_pix_q;

  // Every accepted request yields exactly one strobe after the input and result registers.
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 result_valid_o)
    else $error("accepted request produced no result strobe");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> ##1 !result_valid_o)
    else $error("result strobe without a request");

  // Ranks of the used pixels form a permutation: exactly one hits the middle.
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ctrl_q.valid && (in_ctrl_q.count != '0)) |-> $onehot(hit))
    else $error("median selection not unique");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ctrl_q.valid && (in_ctrl_q.count == '0)) |=> (median_pixel_o == '0))
    else $error("empty stack must give zero");

endmodule

// ----- test/image_stack_median_core_test.sv -----
// Self-checking testbench for image_stack_median_core: directed table, then random stacks.
// Depends on ism_pkg and the image_stack_median_core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module image_stack_median_core_test;
  import ism_pkg::*;

  localparam int PixW = 8;
  localparam int NumDirected = 19;
  localparam int NumPhases = 16;
  localparam int ItemsPerPhase = 80;
  // Idle cycles with no handshake of any kind before the run is declared hung.
  localparam int HangLimit = 1000;

  typedef logic [PixW-1:0] pix_t;
  // One request: pixel of image i sits in element i.
  typedef logic [MaxImages-1:0][PixW-1:0] stack_t;

  // Directed row: images-in-use setting, pixel stack, and the median where it is obvious.
  typedef struct packed {
    cnt_t   count;
    stack_t px;
    logic   known;
    pix_t   median;
  } dir_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_valid_i;
  logic   cfg_ready_o;
  cnt_t   cfg_images_in_use_i;
  logic   start_i;
  logic   busy_o;
  stack_t pix_drv;
  logic   result_valid_o;
  pix_t   median_pixel_o;

  // Medians still owed by the core, oldest first.
  pix_t   pending_medians [$];
  // Images-in-use value the core holds, tracked on every register write.
  cnt_t   active_count = CountReset;
  int     failures = 0;
  int     idle_cycles = 0;

  // Rows are grouped by setting so that the register is rewritten only when it changes.
  dir_row_t directed_rows [NumDirected] = '{
    // full stack: all low, all high, ramps both ways, alternating and spread patterns
    '{4'd9,  72'h00_00_00_00_00_00_00_00_00, 1'b1, 8'h00},
    '{4'd9,  72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1, 8'hFF},
    '{4'd9,  72'h08_07_06_05_04_03_02_01_00, 1'b1, 8'h04},
    '{4'd9,  72'h00_01_02_03_04_05_06_07_08, 1'b1, 8'h04},
    '{4'd9,  72'hFF_00_FF_00_FF_00_FF_00_FF, 1'b1, 8'hFF},
    '{4'd9,  72'hFF_80_40_20_10_08_04_02_01, 1'b1, 8'h10},
    '{4'd9,  72'hAA_55_AA_55_AA_55_AA_55_AA, 1'b0, 8'h00},
    // a single image passes its own pixel
    '{4'd1,  72'hFF_FF_FF_FF_FF_FF_FF_FF_5A, 1'b1, 8'h5A},
    '{4'd1,  72'hFF_FF_FF_FF_FF_FF_FF_FF_00, 1'b1, 8'h00},
    // even count picks the lower middle
    '{4'd2,  72'h00_00_00_00_00_00_00_F0_10, 1'b1, 8'h10},
    '{4'd2,  72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1, 8'hFF},
    // count of zero returns zero
    '{4'd0,  72'h12_34_56_78_9A_BC_DE_F0_11, 1'b1, 8'h00},
    '{4'd0,  72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1, 8'h00},
    // counts above the stack depth saturate to the full stack
    '{4'd15, 72'h08_07_06_05_04_03_02_01_00, 1'b1, 8'h04},
    '{4'd10, 72'h00_00_00_00_00_FF_FF_FF_FF, 1'b1, 8'h00},
    // unused slots hold values that would change the answer if they leaked in
    '{4'd4,  72'hFF_FF_FF_FF_FF_20_30_10_40, 1'b1, 8'h20},
    '{4'd3,  72'h00_00_00_00_00_00_81_80_7F, 1'b1, 8'h80},
    '{4'd8,  72'h13_C4_7E_02_E9_55_A0_31_8F, 1'b0, 8'h00},
    '{4'd5,  72'h00_00_00_00_33_77_33_77_33, 1'b0, 8'h00}
  };

  // Random phases walk every register value, extremes included.
  cnt_t phase_counts [NumPhases] = '{
    4'd1, 4'd2, 4'd0, 4'd15, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd7, 4'd8, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd9
  };

  image_stack_median_core #(
    .PIXEL_BITS(PixW)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_images_in_use_i (cfg_images_in_use_i),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .pixel_0_i           (pix_drv[0]),
    .pixel_1_i           (pix_drv[1]),
    .pixel_2_i           (pix_drv[2]),
    .pixel_3_i           (pix_drv[3]),
    .pixel_4_i           (pix_drv[4]),
    .pixel_5_i           (pix_drv[5]),
    .pixel_6_i           (pix_drv[6]),
    .pixel_7_i           (pix_drv[7]),
    .pixel_8_i           (pix_drv[8]),
    .result_valid_o      (result_valid_o),
    .median_pixel_o      (median_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Median of the first images-in-use pixels, ranked largest first.
  function automatic pix_t stack_median(stack_t s, cnt_t cnt);
    int   n;
    pix_t ranked [MaxImages];
    pix_t swap;
    n = (cnt > MaxImages) ? MaxImages : int'(cnt);
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) ranked[i] = s[i];
    // selection sort, descending
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (ranked[j] > ranked[i]) begin
          swap = ranked[i];
          ranked[i] = ranked[j];
          ranked[j] = swap;
        end
      end
    end
    return ranked[n / 2];
  endfunction

  // Mostly short gaps, some medium, a rare long one.
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Pixel stacks shaped to hit ties, extremes and ordered runs, not just uniform noise.
  function automatic stack_t random_stack();
    stack_t s;
    pix_t   base;
    pix_t   step;
    pix_t   trio [3];
    int     mode;
    mode = $urandom_range(0, 9);
    base = pix_t'($urandom);
    step = pix_t'($urandom_range(0, 40));
    for (int k = 0; k < 3; k++) trio[k] = pix_t'($urandom);
    for (int i = 0; i < MaxImages; i++) begin
      case (mode)
        5, 6: s[i] = trio[$urandom_range(0, 2)];
        7: s[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        8: s[i] = pix_t'(base + i * step);
        9: s[i] = base;
        default: s[i] = pix_t'($urandom);
      endcase
    end
    return s;
  endfunction

  // Hold the request until accepted, book its median, then idle for the gap.
  task automatic send_stack(stack_t s, logic known, pix_t median, int gap);
    start_i <= 1'b1;
    pix_drv <= s;
    do @(posedge clk_i); while (busy_o);
    pending_medians.push_back(known ? median : stack_median(s, active_count));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) begin
        // drive noise on the pixels while no request is offered
        pix_drv <= stack_t'({$urandom, $urandom, $urandom});
        @(posedge clk_i);
      end
    end
  endtask

  // Stop offering requests and wait until every booked median has come back.
  task automatic drain_requests();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_medians.size() != 0) @(posedge clk_i);
    // cover the pipeline depth once more before touching the register
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_images_in_use(cnt_t value);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_images_in_use_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    active_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_failure(string what, pix_t want, pix_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s: expected median %02h, got %02h", $realtime, what, want, got);
    end
  endtask

  // Result checker: each strobe retires the oldest booked median.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_medians.size() == 0) begin
        report_failure("median with no request outstanding", '0, median_pixel_o);
      end else if (median_pixel_o !== pending_medians[0]) begin
        report_failure("median mismatch", pending_medians[0], median_pixel_o);
        void'(pending_medians.pop_front());
      end else begin
        void'(pending_medians.pop_front());
      end
    end
  end

  // Hang watchdog: any request, result or register handshake resets the count.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == HangLimit) begin
      $display("image_stack_median_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    int gap;
    logic no_gaps;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_images_in_use_i = '0;
    start_i = 1'b0;
    pix_drv = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: rewrite the register only where the row's setting differs.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].count != active_count) begin
        write_images_in_use(directed_rows[r].count);
      end
      send_stack(directed_rows[r].px, directed_rows[r].known, directed_rows[r].median,
                 random_gap());
    end

    // Random part: one phase per setting, some phases back to back with no idling.
    for (int p = 0; p < NumPhases; p++) begin
      write_images_in_use(phase_counts[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        // hold off mid-phase until the core has returned everything
        if (p == 5 && k == ItemsPerPhase / 2) drain_requests();
        gap = no_gaps ? 0 : random_gap();
        send_stack(random_stack(), 1'b0, '0, gap);
      end
    end

    drain_requests();
    repeat (8) @(posedge clk_i);
    if (failures == 0 && pending_medians.size() == 0) begin
      $display("image_stack_median_core_test: PASS");
    end else begin
      $display("image_stack_median_core_test: FAIL");
    end
    $finish;
  end

endmodule
